/* hdl/gdck_pkg.sv */
// Shared types, constants and helpers for the grayscale duotone color keep block.
package gdck_pkg;

	localparam int ATAN_FRACTION_BITS = 12;
	localparam int FB = ATAN_FRACTION_BITS;
	localparam int CORDIC_STAGES = 28;
	localparam int LATENCY = 5 + CORDIC_STAGES + 4;

	localparam int XQ_W = 12 + FB;
	localparam int CW = 46;
	localparam int ZW = 33;
	localparam int A_W = FB + 2;
	localparam int A101_W = A_W + 7;
	localparam int W_W = FB + 2;
	localparam int PROD_W = W_W + 12;

	localparam logic [29:0] ATAN_SCALE = 30'd683565276;
	localparam logic [31:0] RECIP100 = 32'd42949673;
	localparam logic [16:0] RECIP3 = 17'd43691;

	localparam logic [2:0] REG_RED_WEIGHT = 3'd0;
	localparam logic [2:0] REG_GREEN_WEIGHT = 3'd1;
	localparam logic [2:0] REG_BLUE_WEIGHT = 3'd2;
	localparam logic [2:0] REG_MODE = 3'd3;
	localparam logic [2:0] REG_DARK_COLOR = 3'd4;
	localparam logic [2:0] REG_BRIGHT_COLOR = 3'd5;
	localparam logic [2:0] REG_KEEP_COLOR = 3'd6;
	localparam logic [2:0] REG_KEEP_RATIO = 3'd7;

	localparam logic [1:0] SEL_GRAY = 2'd0;
	localparam logic [1:0] SEL_PASS = 2'd1;
	localparam logic [1:0] SEL_BLEND = 2'd2;

	localparam logic [31:0] ATAN_LOW [10] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
		32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149
	};

	typedef struct packed {
		logic [9:0]  red_weight;
		logic [9:0]  green_weight;
		logic [9:0]  blue_weight;
		logic [1:0]  mode;
		logic [26:0] dark_color;
		logic [26:0] bright_color;
		logic [23:0] keep_color;
		logic [8:0]  keep_ratio;
	} cfg_t;

	typedef struct packed {
		logic [XQ_W-1:0] xq;
		logic [9:0]      v;
		logic [7:0]      c;
		logic [1:0]      sel;
	} lane_in_t;

	typedef struct packed {
		logic [9:0] v;
		logic [7:0] c;
		logic [1:0] sel;
	} lane_meta_t;

	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] r;
		if (i < 10) begin
			r = ATAN_LOW[i];
		end else begin
			r = 32'd1 << (30 - i);
		end
		return r;
	endfunction

endpackage

/* hdl/gdck_if.sv */
// Pixel request channel interfaces.
interface gdck_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;
	modport source (output valid, output in_red, output in_green, output in_blue, input ready);
	modport sink (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

interface gdck_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	modport source (output valid, output out_red, output out_green, output out_blue, input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue, output ready);
endinterface

/* hdl/gdck_front.sv */
// Shared front end: gray level, duotone value and keep argument for each lane.
module gdck_front (
	input  logic                          clk,
	input  logic                          en,
	input  logic [2:0][7:0]               ch,
	input  gdck_pkg::cfg_t                cfg,
	output gdck_pkg::lane_in_t [2:0]      lanes
);
	import gdck_pkg::*;

	logic [2:0][7:0]  ch_s1, ch_s2, ch_s3;
	logic [19:0]      sum_s2;
	logic [16:0]      d2_s2;
	logic [2:0]       eq_s2, eq_s3;
	logic [7:0]       gray_s3;
	logic [32:0]      d4_s3;
	logic [2:0][10:0] diff5_s3;
	logic [8:0]       d_c;
	logic [28:0]      gq_c;
	logic [2:0][9:0]  v_c;
	logic [2:0][43:0] m_c;

	assign d_c = (cfg.keep_ratio > 9'd256) ? cfg.keep_ratio - 9'd256 : 9'd256 - cfg.keep_ratio;
	assign gq_c = 29'(sum_s2[19:8]) * 29'(RECIP3);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic [17:0] mix;
			mix = 18'(gray_s3) * 18'(cfg.bright_color[9*k +: 9])
				+ 18'(cfg.dark_color[9*k +: 9]) * 18'(8'd255 - gray_s3);
			v_c[k] = cfg.mode[0] ? mix[17:8] : {2'b00, gray_s3};
			m_c[k] = 44'(diff5_s3[k]) * 44'(d4_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ch_s1 <= ch;
			ch_s2 <= ch_s1;
			ch_s3 <= ch_s2;
			sum_s2 <= 20'(ch_s1[0]) * 20'(cfg.red_weight) + 20'(ch_s1[1]) * 20'(cfg.green_weight)
				+ 20'(ch_s1[2]) * 20'(cfg.blue_weight);
			d2_s2 <= 17'(d_c) * 17'(d_c);
			d4_s3 <= 33'(d2_s2) * 33'(d2_s2);
			gray_s3 <= (gq_c[28:17] > 12'd255) ? 8'd255 : gq_c[24:17];
			eq_s3 <= eq_s2;
			for (int k = 0; k < 3; k++) begin
				logic [7:0] t;
				logic [7:0] df;
				t = cfg.keep_color[8*k +: 8];
				df = (ch_s2[k] > t) ? ch_s2[k] - t : t - ch_s2[k];
				eq_s2[k] <= (ch_s1[k] == cfg.keep_color[8*k +: 8]);
				diff5_s3[k] <= 11'(df) * 11'd5;
				lanes[k].xq <= m_c[k][32-FB +: XQ_W];
				lanes[k].v <= v_c[k];
				lanes[k].c <= ch_s3[k];
				if (!cfg.mode[1]) begin
					lanes[k].sel <= SEL_GRAY;
				end else if (eq_s3[k]) begin
					lanes[k].sel <= SEL_PASS;
				end else if (cfg.keep_ratio == 9'd0) begin
					lanes[k].sel <= SEL_GRAY;
				end else if (m_c[k][32-FB +: XQ_W] == '0) begin
					lanes[k].sel <= SEL_PASS;
				end else begin
					lanes[k].sel <= SEL_BLEND;
				end
			end
		end
	end

endmodule

/* hdl/gdck_lane.sv */
// One channel lane: CORDIC arctangent pipeline, keep weight and blend.
module gdck_lane (
	input  logic               clk,
	input  logic               en,
	input  gdck_pkg::lane_in_t li,
	output logic [7:0]         res_s37
);
	import gdck_pkg::*;

	logic signed [CW-1:0] cx_sk [1:CORDIC_STAGES];
	logic signed [CW-1:0] cy_sk [1:CORDIC_STAGES];
	logic signed [ZW-1:0] z_sk [1:CORDIC_STAGES];
	lane_meta_t           meta_sk [1:CORDIC_STAGES];

	for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cordic
		logic signed [CW-1:0] xi, yi;
		logic signed [ZW-1:0] zi, ai;
		lane_meta_t           mi;
		if (gi == 0) begin : g_first
			assign xi = CW'(64'd1 << 30);
			assign yi = CW'(li.xq) <<< (30 - FB);
			assign zi = '0;
			assign mi = '{v: li.v, c: li.c, sel: li.sel};
		end else begin : g_next
			assign xi = cx_sk[gi];
			assign yi = cy_sk[gi];
			assign zi = z_sk[gi];
			assign mi = meta_sk[gi];
		end
		assign ai = ZW'(atan_q30(gi));
		always_ff @(posedge clk) begin
			if (en) begin
				meta_sk[gi+1] <= mi;
				if (!yi[CW-1]) begin
					cx_sk[gi+1] <= xi + (yi >>> gi);
					cy_sk[gi+1] <= yi - (xi >>> gi);
					z_sk[gi+1] <= zi + ai;
				end else begin
					cx_sk[gi+1] <= xi - (yi >>> gi);
					cy_sk[gi+1] <= yi + (xi >>> gi);
					z_sk[gi+1] <= zi - ai;
				end
			end
		end
	end

	logic [31:0]              zp_c;
	logic [61:0]              az_s33;
	logic [A101_W-1:0]        a101_s34;
	logic [W_W-1:0]           w_s35;
	logic signed [PROD_W-1:0] prod_s36;
	lane_meta_t               meta_s33, meta_s34, meta_s35, meta_s36;
	logic [A_W-1:0]           a_c;
	logic [52:0]              wq_c;
	logic signed [10:0]       dv_c;
	logic signed [PROD_W-1:0] q_c;
	logic signed [PROD_W:0]   r_c;
	logic [7:0]               blend_c;

	assign zp_c = z_sk[CORDIC_STAGES][ZW-1] ? 32'd0 : z_sk[CORDIC_STAGES][31:0];
	assign a_c = az_s33[60-FB +: A_W];
	assign wq_c = 53'(a101_s34) * 53'(RECIP100);
	assign dv_c = $signed({1'b0, meta_s35.v}) - $signed({3'b000, meta_s35.c});
	assign q_c = (prod_s36 + (prod_s36[PROD_W-1] ? PROD_W'((1 << FB) - 1) : PROD_W'(0))) >>> FB;
	assign r_c = $signed({{(PROD_W-7){1'b0}}, meta_s36.c}) + (PROD_W+1)'(q_c);
	assign blend_c = r_c[PROD_W] ? 8'd0 : ((r_c > (PROD_W+1)'(255)) ? 8'd255 : r_c[7:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			az_s33 <= 62'(zp_c) * 62'(ATAN_SCALE);
			meta_s33 <= meta_sk[CORDIC_STAGES];
			a101_s34 <= A101_W'(a_c) * A101_W'(7'd101);
			meta_s34 <= meta_s33;
			w_s35 <= wq_c[32 +: W_W];
			meta_s35 <= meta_s34;
			prod_s36 <= PROD_W'($signed({1'b0, w_s35}) * dv_c);
			meta_s36 <= meta_s35;
			case (meta_s36.sel)
				SEL_PASS: res_s37 <= meta_s36.c;
				SEL_BLEND: res_s37 <= blend_c;
				default: res_s37 <= (meta_s36.v > 10'd255) ? 8'd255 : meta_s36.v[7:0];
			endcase
		end
	end

endmodule

/* hdl/grayscale_duotone_color_keep.sv */
// Top level: configuration registers, shared front end, three channel lanes, output merge.
// Throughput: one pixel per cycle; the 28-stage CORDIC pipeline in each lane makes up most of the latency.
// The whole pipeline holds while the output request waits and is not taken.
// Reset: arst_n clears valid bits and loads register defaults (weights 1.0, ratio 1.0).
module grayscale_duotone_color_keep (
	input  logic        clk,
	input  logic        arst_n,
	gdck_in_if.sink     pixel,
	gdck_out_if.source  converted,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [26:0] cfg_data
);
	import gdck_pkg::*;

	cfg_t                cfg_q;
	logic [LATENCY:1]    vld_q;
	logic                en;
	logic [2:0][7:0]     ch;
	lane_in_t [2:0]      lanes;
	logic [2:0][7:0]     res;

	assign en = !vld_q[LATENCY] || converted.ready;
	assign pixel.ready = en;
	assign ch = {pixel.in_blue, pixel.in_green, pixel.in_red};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_weight <= 10'd256;
			cfg_q.green_weight <= 10'd256;
			cfg_q.blue_weight <= 10'd256;
			cfg_q.mode <= 2'd0;
			cfg_q.dark_color <= '0;
			cfg_q.bright_color <= '0;
			cfg_q.keep_color <= '0;
			cfg_q.keep_ratio <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RED_WEIGHT: cfg_q.red_weight <= cfg_data[9:0];
				REG_GREEN_WEIGHT: cfg_q.green_weight <= cfg_data[9:0];
				REG_BLUE_WEIGHT: cfg_q.blue_weight <= cfg_data[9:0];
				REG_MODE: cfg_q.mode <= cfg_data[1:0];
				REG_DARK_COLOR: cfg_q.dark_color <= cfg_data;
				REG_BRIGHT_COLOR: cfg_q.bright_color <= cfg_data;
				REG_KEEP_COLOR: cfg_q.keep_color <= cfg_data[23:0];
				REG_KEEP_RATIO: cfg_q.keep_ratio <= cfg_data[8:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// advance valid bits with the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LATENCY-1:1], pixel.valid};
		end
	end

	gdck_front u_front (
		.clk   (clk),
		.en    (en),
		.ch    (ch),
		.cfg   (cfg_q),
		.lanes (lanes)
	);

	for (genvar k = 0; k < 3; k++) begin : g_lane
		gdck_lane u_lane (
			.clk     (clk),
			.en      (en),
			.li      (lanes[k]),
			.res_s37 (res[k])
		);
	end

	assign converted.valid = vld_q[LATENCY];
	assign converted.out_red = res[0];
	assign converted.out_green = res[1];
	assign converted.out_blue = res[2];

endmodule
